>>> hdl/timed_event_queue_assert.svh
// Assertion macros for the timed event queue.
`ifndef TIMED_EVENT_QUEUE_ASSERT_SVH
`define TIMED_EVENT_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TEQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TEQ_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TEQ_ASSERT(label, clk, rst_n, prop, msg)
`define TEQ_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

>>> hdl/teq_pkg.sv
// Package with types and constants for the timed event queue.
package teq_pkg;
  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int DUE_W = 41;

  typedef enum logic [1:0] {
    REQ_SCHED    = 2'd0,
    REQ_POLL     = 2'd1,
    REQ_KILL     = 2'd2,
    REQ_KILL_TAG = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_HEAD,
    ST_POP,
    ST_KILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        event_kind;
    logic [15:0] target_id;
    logic [31:0] value_word;
    logic [39:0] base_ms;
    logic [30:0] offset_ms;
    logic [40:0] current_ms;
    logic [15:0] process_id;
    logic [15:0] tag_value;
  } in_item_t;

  typedef struct packed {
    logic        fired;
    logic        out_kind;
    logic [15:0] out_target;
    logic [31:0] out_value;
    logic [15:0] out_process;
    logic [15:0] out_tag;
    logic [31:0] wait_ms;
    logic        queue_empty;
    logic        dropped;
    logic [6:0]  removed_count;
  } out_item_t;

  // One stored event.
  typedef struct packed {
    logic [DUE_W-1:0] due;
    logic             kind;
    logic [15:0]      target;
    logic [31:0]      value;
    logic [15:0]      owner;
    logic [15:0]      label;
  } entry_t;
endpackage

>>> hdl/timed_event_queue.sv
// Top level of the timed event queue: sequencer, comparator and memory.
//
// The timed event queue keeps up to 64 events sorted by due time in one
// memory with a single read and a single write port, walked by a small
// sequencer that reads one entry per cycle. A schedule reads entries from the
// tail toward the head, moving each later entry up one slot, and writes the new
// event when it meets an entry due at or before it. A poll reads the head
// and, when it fires, moves every other entry down one slot. A kill reads every
// entry once and writes back the survivors in order. The memory read port sets
// the pace: one entry per cycle. The result sits in its own output register, so
// the next item can be taken while it waits; a finished item waits until that
// register is free.
module timed_event_queue import teq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  state_t           state_r, state_nxt;
  in_item_t         req_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_r, rd_nxt;     // read pointer
  logic [CNT_W-1:0] wr_r, wr_nxt;     // write pointer for compaction
  logic [CNT_W-1:0] rd_pend_r;        // address of the data now on the read port
  logic             rd_live_r;        // read data valid this cycle
  logic [6:0]       removed_r, removed_nxt;
  out_item_t        res_r, res_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;
  entry_t           new_entry;
  logic [DUE_W-1:0] new_due;
  logic             rd_issue;
  logic [DUE_W:0]   head_diff;
  logic             hit;
  logic             q_full;

  function automatic req_t req_type_of(input in_item_t it);
    return req_t'(it.req_type);
  endfunction

  assign new_due = DUE_W'(req_r.base_ms) + DUE_W'(req_r.offset_ms);
  assign new_entry = '{due: new_due, kind: req_r.event_kind, target: req_r.target_id,
                       value: req_r.value_word, owner: req_r.process_id,
                       label: req_r.tag_value};
  assign head_diff = {1'b0, ram_rdata.due} - {1'b0, req_r.current_ms};
  assign hit = (ram_rdata.owner == req_r.process_id) &&
               ((req_type_of(req_r) != REQ_KILL_TAG) ||
                (ram_rdata.label == req_r.tag_value));
  assign q_full = (count_r == CNT_W'(QUEUE_DEPTH));

  teq_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign ram_raddr = rd_r[IDX_W-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (req_t'(in_data.req_type))
            REQ_SCHED: begin
              state_nxt = q_full ? ST_DONE : ST_SEARCH;
            end
            REQ_POLL: begin
              state_nxt = (count_r == '0) ? ST_DONE : ST_HEAD;
            end
            REQ_KILL, REQ_KILL_TAG: begin
              state_nxt = ST_KILL;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SEARCH: begin
        if (rd_live_r && ram_rdata.due <= new_due) begin
          state_nxt = ST_DONE;
        end else if (!rd_live_r && !rd_issue) begin
          state_nxt = ST_DONE;
        end
      end
      ST_HEAD: begin
        if (rd_live_r) begin
          state_nxt = (head_diff[DUE_W] || head_diff == '0) ? ST_POP : ST_DONE;
        end
      end
      ST_POP, ST_KILL: begin
        if (!rd_live_r && !rd_issue) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    count_nxt     = count_r;
    removed_nxt   = removed_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = new_entry;
    rd_issue      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        res_nxt     = '0;
        removed_nxt = '0;
        wr_nxt      = '0;
        if (in_valid) begin
          unique case (req_t'(in_data.req_type))
            REQ_SCHED: begin
              rd_nxt = count_r - CNT_W'(1);
              res_nxt.dropped = q_full;
            end
            REQ_POLL: rd_nxt = '0;
            default:  rd_nxt = '0;
          endcase
        end
      end
      ST_SEARCH: begin
        // Walk from the tail; rd_r holds the next address to read. When the
        // head itself moves up, the new event goes to slot zero in the next cycle.
        rd_issue = (rd_r != '1) && !(rd_live_r && ram_rdata.due <= new_due);
        if (rd_live_r && ram_rdata.due <= new_due) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(rd_pend_r + CNT_W'(1));
          count_nxt = count_r + CNT_W'(1);
        end else if (rd_live_r) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(rd_pend_r + CNT_W'(1));
          ram_wdata = ram_rdata;
        end else if (!rd_issue) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          count_nxt = count_r + CNT_W'(1);
        end
        if (rd_issue) begin
          rd_nxt = rd_r - CNT_W'(1);
        end
      end
      ST_HEAD: begin
        if (rd_live_r) begin
          if (head_diff[DUE_W] || head_diff == '0) begin
            res_nxt.fired       = 1'b1;
            res_nxt.out_kind    = ram_rdata.kind;
            res_nxt.out_target  = ram_rdata.target;
            res_nxt.out_value   = ram_rdata.value;
            res_nxt.out_process = ram_rdata.owner;
            res_nxt.out_tag     = ram_rdata.label;
            rd_nxt              = CNT_W'(1);
            count_nxt           = count_r - CNT_W'(1);
          end else if (head_diff[DUE_W-1:32] != '0) begin
            res_nxt.wait_ms = '1;
          end else begin
            res_nxt.wait_ms = head_diff[31:0];
          end
        end
      end
      ST_POP: begin
        // Entry k moves to slot k-1; count_r already holds the new length.
        rd_issue = (rd_r <= count_r);
        if (rd_issue) begin
          rd_nxt = rd_r + CNT_W'(1);
        end
        if (rd_live_r) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(rd_pend_r - CNT_W'(1));
          ram_wdata = ram_rdata;
        end
      end
      ST_KILL: begin
        rd_issue = (rd_r < count_r);
        if (rd_issue) begin
          rd_nxt = rd_r + CNT_W'(1);
        end
        if (rd_live_r) begin
          if (hit) begin
            if (removed_r != 7'h7f) begin
              removed_nxt = removed_r + 7'd1;
            end
          end else begin
            ram_we    = 1'b1;
            ram_waddr = wr_r[IDX_W-1:0];
            ram_wdata = ram_rdata;
            wr_nxt    = wr_r + CNT_W'(1);
          end
        end
        if (!rd_live_r && !rd_issue) begin
          count_nxt             = wr_r;
          res_nxt.removed_count = removed_r;
        end
      end
      ST_DONE: begin
        // Hand the finished item to the output register once it is free.
        if (!out_valid_r || out_ready) begin
          out_nxt             = res_r;
          out_nxt.queue_empty = (count_r == '0);
          out_valid_nxt       = 1'b1;
        end
      end
      default: ;
    endcase
    if (state_r == ST_HEAD && !rd_live_r) begin
      rd_issue = 1'b1;
    end
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rd_live_r   <= 1'b0;
      out_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      rd_live_r   <= rd_issue && (state_nxt == state_r) && (state_r != ST_HEAD ||
                     !rd_live_r);
      out_r       <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_data;
    end
    rd_r      <= rd_nxt;
    wr_r      <= wr_nxt;
    rd_pend_r <= rd_r;
    removed_r <= removed_nxt;
    res_r     <= res_nxt;
  end

  `include "timed_event_queue_assert.svh"

  `TEQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(QUEUE_DEPTH), "count overflow")
  `TEQ_ASSERT(a_no_take_busy, clk, rst_n, out_valid_r && !out_ready |=> out_valid_r, "result lost")
  `TEQ_ASSERT(a_drop_full, clk, rst_n, $rose(out_valid_r) && out_r.dropped |-> q_full, "drop")
  `TEQ_ASSERT_RST(a_reset_idle, clk, !rst_n |=> state_r == ST_IDLE && !out_valid_r, "reset state")
endmodule

>>> hdl/teq_ram.sv
// Single-port-write, single-port-read entry memory with a registered read.
module teq_ram import teq_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);
  entry_t mem [QUEUE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

>>> verif/tb.sv
// Testbench for the timed event queue: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import teq_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  timed_event_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predictor copy of the pending events, kept in due-time order.
  entry_t    pending[$];
  out_item_t expected_results[$];
  int        mismatch_count;
  bit        idle_enable;
  logic [15:0] proc_pool[4] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h1234};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Work out the result of one request and update the event list.
  function automatic out_item_t predict_request(in_item_t req);
    out_item_t res;
    entry_t    ev;
    logic [40:0] due;
    logic [40:0] diff;
    int pos;
    int removed;
    entry_t kept[$];
    res = '0;
    case (req_t'(req.req_type))
      REQ_SCHED: begin
        if (pending.size() >= QUEUE_DEPTH) begin
          res.dropped = 1'b1;
        end else begin
          due = {1'b0, req.base_ms} + {10'd0, req.offset_ms};
          ev = '{due: due, kind: req.event_kind, target: req.target_id,
                 value: req.value_word, owner: req.process_id, label: req.tag_value};
          pos = 0;
          while (pos < pending.size() && pending[pos].due <= due) pos++;
          pending.insert(pos, ev);
        end
      end
      REQ_POLL: begin
        if (pending.size() > 0) begin
          if (pending[0].due <= req.current_ms) begin
            ev = pending.pop_front();
            res.fired = 1'b1;
            res.out_kind = ev.kind;
            res.out_target = ev.target;
            res.out_value = ev.value;
            res.out_process = ev.owner;
            res.out_tag = ev.label;
          end else begin
            diff = pending[0].due - req.current_ms;
            res.wait_ms = (diff > 41'hFFFFFFFF) ? 32'hFFFFFFFF : diff[31:0];
          end
        end
      end
      default: begin
        removed = 0;
        foreach (pending[i]) begin
          if (pending[i].owner == req.process_id &&
              (req.req_type != REQ_KILL_TAG || pending[i].label == req.tag_value))
            removed++;
          else
            kept.push_back(pending[i]);
        end
        pending = kept;
        res.removed_count = (removed > 127) ? 7'd127 : removed[6:0];
      end
    endcase
    res.queue_empty = (pending.size() == 0);
    return res;
  endfunction

  // Send one item, with a random gap before it when idling is on. Valid is
  // dropped only in a gap or by wait_drained, so each step drives it once.
  task automatic send_request(in_item_t req);
    while (idle_enable && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_request(req));
  endtask

  function automatic in_item_t random_fields();
    in_item_t r;
    logic [223:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = bits[$bits(in_item_t)-1:0];
    r.process_id = proc_pool[$urandom_range(3)];
    r.tag_value  = 16'($urandom_range(3));
    return r;
  endfunction

  function automatic in_item_t make_sched(logic [39:0] base, logic [30:0] offset);
    in_item_t r;
    r = random_fields();
    r.req_type = REQ_SCHED;
    r.base_ms = base;
    r.offset_ms = offset;
    return r;
  endfunction

  function automatic in_item_t make_poll(logic [40:0] now);
    in_item_t r;
    r = random_fields();
    r.req_type = REQ_POLL;
    r.current_ms = now;
    return r;
  endfunction

  function automatic in_item_t make_kill(req_t kind, logic [15:0] proc, logic [15:0] tag);
    in_item_t r;
    r = random_fields();
    r.req_type = kind;
    r.process_id = proc;
    r.tag_value = tag;
    return r;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Result checker: compares each delivered item with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", out_data);
      end else begin
        if (out_data !== expected_results[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %h actual %h", expected_results[0], out_data);
        end
        void'(expected_results.pop_front());
      end
    end
  end

  // Result side stalls.
  always @(posedge clk) begin
    out_ready <= !idle_enable || ($urandom_range(99) >= 28);
  end

  // Polls of an empty queue, extreme times, wait saturation and equal due times.
  task automatic test_directed_edges();
    send_request(make_poll('0));
    send_request(make_kill(REQ_KILL, 16'h0000, 16'h0));
    send_request(make_sched('1, '1));
    send_request(make_poll(41'd0));
    send_request(make_poll({1'b1, 40'hFFFFFFFFFE} + 41'd1 - 41'd1 - 41'h7FFFFFFF));
    send_request(make_poll('1));
    send_request(make_sched(40'd100, 31'd0));
    send_request(make_sched(40'd50, 31'd50));
    send_request(make_sched(40'd0, 31'd100));
    send_request(make_poll(41'd99));
    send_request(make_poll(41'd100));
    send_request(make_poll(41'd100));
    send_request(make_poll(41'd100));
    send_request(make_poll(41'd100));
    send_request(make_sched('0, '0));
    send_request(make_kill(REQ_KILL_TAG, 16'hFFFF, 16'hFFFF));
    send_request(make_kill(REQ_KILL, 16'h5555, 16'h0));
  endtask

  // Fill past the depth so schedules are dropped, then clear with kills.
  task automatic test_full_queue();
    in_item_t r;
    for (int i = 0; i < QUEUE_DEPTH + 3; i++) begin
      r = make_sched(40'($urandom_range(1000)), 31'($urandom_range(1000)));
      send_request(r);
    end
    send_request(make_kill(REQ_KILL_TAG, proc_pool[1], 16'd2));
    send_request(make_kill(REQ_KILL, proc_pool[0], 16'd0));
    for (int i = 0; i < 4; i++) send_request(make_kill(REQ_KILL, proc_pool[i], 16'd0));
  endtask

  // Mostly schedules and polls around a moving clock, with kills mixed in.
  task automatic test_random_traffic(int count);
    logic [40:0] now;
    in_item_t r;
    int pick;
    now = 41'd1000;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (i == count / 2) begin
        wait_drained();
        idle_enable = 1'b0;
      end
      if (i == count / 2 + 200) idle_enable = 1'b1;
      if (pick < 45) begin
        r = ($urandom_range(19) == 0) ? random_fields() :
            make_sched(now[39:0], 31'($urandom_range(300)));
        r.req_type = REQ_SCHED;
      end else if (pick < 85) begin
        now = now + 41'($urandom_range(20));
        r = ($urandom_range(19) == 0) ? make_poll(41'({$urandom, $urandom})) :
            make_poll(now);
      end else begin
        r = make_kill(pick[0] ? REQ_KILL : REQ_KILL_TAG,
                      proc_pool[$urandom_range(3)], 16'($urandom_range(3)));
      end
      send_request(r);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    mismatch_count = 0;
    idle_enable = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_full_queue();
    wait_drained();
    test_random_traffic(1500);
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(12 * 1600 * 400);
    $display("tb: errors");
    $finish;
  end
endmodule
